// File: hdl/bale_pkg.sv
// Shared types and codes for the bounded array list engine.
// Used by bale_seq, bale_dp and bounded_array_list_engine_core; no dependencies.
package bale_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int ID_W             = 32;
   localparam int AGE_W            = 8;
   localparam int ENTRY_W          = ID_W + AGE_W;
   localparam int UPC_W            = 5;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [1:0] {
      OP_INS = 2'd0,
      OP_DEL = 2'd1,
      OP_LOC = 2'd2,
      OP_SRT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BADPOS   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Datapath action selected by one control word.
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_INS_INIT,
      ACT_SCAN_INIT,
      ACT_SCAN,
      ACT_IDX_CNT,
      ACT_PTR_CNT,
      ACT_SHIFT_UP,
      ACT_PLACE,
      ACT_DEL_INIT,
      ACT_SHIFT_DN,
      ACT_CNT_DEC,
      ACT_EMIT
   } act_type;

   // Jump condition of one control word.
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_DISPATCH,
      C_NO_REQ,
      C_INS_BAD,
      C_FULL,
      C_EMPTY,
      C_DEL_BAD,
      C_SCAN_BUSY,
      C_SHIFT_BUSY,
      C_FOUND,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      act_type    act;
      logic       st_set;
      status_type st;
      cond_type   cond;
      upc_type    tgt;
   } ucode_type;

   // Sequencer to datapath.
   typedef struct packed {
      act_type    act;
      logic       st_set;
      status_type st;
   } ctl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic   no_req;
      logic   ins_bad;
      logic   full;
      logic   empty;
      logic   del_bad;
      logic   scan_busy;
      logic   shift_busy;
      logic   found;
      logic   out_busy;
      op_type op;
   } flags_type;

endpackage

// File: hdl/bale_seq.sv
// Microcode sequencer: control ROM, micro program counter and jump logic.
// Depends on bale_pkg.
module bale_seq (
   input  logic                clock,
   input  logic                reset,
   input  bale_pkg::flags_type flags,
   output bale_pkg::ctl_type   ctl
);
   import bale_pkg::*;

   localparam upc_type U_IDLE      = 5'd0;
   localparam upc_type U_DISP      = 5'd1;
   localparam upc_type U_INS       = 5'd2;
   localparam upc_type U_INS_FULL  = 5'd3;
   localparam upc_type U_INS_INIT  = 5'd4;
   localparam upc_type U_SRT       = 5'd5;
   localparam upc_type U_SRT_INIT  = 5'd6;
   localparam upc_type U_SRT_SCAN  = 5'd7;
   localparam upc_type U_SRT_TEST  = 5'd8;
   localparam upc_type U_SRT_END   = 5'd9;
   localparam upc_type U_SRT_PREP  = 5'd10;
   localparam upc_type U_SHUP      = 5'd11;
   localparam upc_type U_PLACE     = 5'd12;
   localparam upc_type U_DEL       = 5'd13;
   localparam upc_type U_DEL_BAD   = 5'd14;
   localparam upc_type U_DEL_INIT  = 5'd15;
   localparam upc_type U_SHDN      = 5'd16;
   localparam upc_type U_DEL_DONE  = 5'd17;
   localparam upc_type U_LOC       = 5'd18;
   localparam upc_type U_LOC_SCAN  = 5'd19;
   localparam upc_type U_LOC_TEST  = 5'd20;
   localparam upc_type U_LOC_MISS  = 5'd21;
   localparam upc_type U_LOC_HIT   = 5'd22;
   localparam upc_type U_BADPOS    = 5'd23;
   localparam upc_type U_FULL      = 5'd24;
   localparam upc_type U_EMPTY     = 5'd25;
   localparam upc_type U_RESP      = 5'd26;
   localparam upc_type U_EMIT      = 5'd27;

   function automatic ucode_type mk(input act_type a, input logic s, input status_type st,
                                    input cond_type c, input upc_type t);
      ucode_type w;
      w.act    = a;
      w.st_set = s;
      w.st     = st;
      w.cond   = c;
      w.tgt    = t;
      return w;
   endfunction

   function automatic ucode_type rom_word(input upc_type a);
      ucode_type w;
      unique case (a)
         U_IDLE:     w = mk(ACT_ACCEPT,    1'b0, ST_OK,       C_NO_REQ,     U_IDLE);
         U_DISP:     w = mk(ACT_NONE,      1'b0, ST_OK,       C_DISPATCH,   U_IDLE);
         U_INS:      w = mk(ACT_NONE,      1'b0, ST_OK,       C_INS_BAD,    U_BADPOS);
         U_INS_FULL: w = mk(ACT_NONE,      1'b0, ST_OK,       C_FULL,       U_FULL);
         U_INS_INIT: w = mk(ACT_INS_INIT,  1'b0, ST_OK,       C_ALWAYS,     U_SHUP);
         U_SRT:      w = mk(ACT_NONE,      1'b0, ST_OK,       C_FULL,       U_FULL);
         U_SRT_INIT: w = mk(ACT_SCAN_INIT, 1'b0, ST_OK,       C_NEVER,      U_IDLE);
         U_SRT_SCAN: w = mk(ACT_SCAN,      1'b0, ST_OK,       C_SCAN_BUSY,  U_SRT_SCAN);
         U_SRT_TEST: w = mk(ACT_NONE,      1'b0, ST_OK,       C_FOUND,      U_SRT_PREP);
         U_SRT_END:  w = mk(ACT_IDX_CNT,   1'b0, ST_OK,       C_NEVER,      U_IDLE);
         U_SRT_PREP: w = mk(ACT_PTR_CNT,   1'b0, ST_OK,       C_NEVER,      U_IDLE);
         U_SHUP:     w = mk(ACT_SHIFT_UP,  1'b0, ST_OK,       C_SHIFT_BUSY, U_SHUP);
         U_PLACE:    w = mk(ACT_PLACE,     1'b1, ST_OK,       C_ALWAYS,     U_RESP);
         U_DEL:      w = mk(ACT_NONE,      1'b0, ST_OK,       C_EMPTY,      U_EMPTY);
         U_DEL_BAD:  w = mk(ACT_NONE,      1'b0, ST_OK,       C_DEL_BAD,    U_BADPOS);
         U_DEL_INIT: w = mk(ACT_DEL_INIT,  1'b0, ST_OK,       C_NEVER,      U_IDLE);
         U_SHDN:     w = mk(ACT_SHIFT_DN,  1'b0, ST_OK,       C_SHIFT_BUSY, U_SHDN);
         U_DEL_DONE: w = mk(ACT_CNT_DEC,   1'b1, ST_OK,       C_ALWAYS,     U_RESP);
         U_LOC:      w = mk(ACT_SCAN_INIT, 1'b0, ST_OK,       C_NEVER,      U_IDLE);
         U_LOC_SCAN: w = mk(ACT_SCAN,      1'b0, ST_OK,       C_SCAN_BUSY,  U_LOC_SCAN);
         U_LOC_TEST: w = mk(ACT_NONE,      1'b0, ST_OK,       C_FOUND,      U_LOC_HIT);
         U_LOC_MISS: w = mk(ACT_NONE,      1'b1, ST_NOTFOUND, C_ALWAYS,     U_RESP);
         U_LOC_HIT:  w = mk(ACT_NONE,      1'b1, ST_OK,       C_ALWAYS,     U_RESP);
         U_BADPOS:   w = mk(ACT_NONE,      1'b1, ST_BADPOS,   C_ALWAYS,     U_RESP);
         U_FULL:     w = mk(ACT_NONE,      1'b1, ST_FULL,     C_ALWAYS,     U_RESP);
         U_EMPTY:    w = mk(ACT_NONE,      1'b1, ST_EMPTY,    C_ALWAYS,     U_RESP);
         U_RESP:     w = mk(ACT_NONE,      1'b0, ST_OK,       C_OUT_BUSY,   U_RESP);
         U_EMIT:     w = mk(ACT_EMIT,      1'b0, ST_OK,       C_ALWAYS,     U_IDLE);
         default:    w = mk(ACT_NONE,      1'b0, ST_OK,       C_ALWAYS,     U_IDLE);
      endcase
      return w;
   endfunction

   function automatic upc_type dispatch(input op_type op);
      upc_type t;
      unique case (op)
         OP_INS:  t = U_INS;
         OP_DEL:  t = U_DEL;
         OP_LOC:  t = U_LOC;
         OP_SRT:  t = U_SRT;
         default: t = U_IDLE;
      endcase
      return t;
   endfunction

   upc_type   upc_ff;
   upc_type   upc_in;
   ucode_type cw;
   logic      take;

   assign cw = rom_word(upc_ff);

   always_comb begin
      unique case (cw.cond)
         C_NEVER:      take = 1'b0;
         C_ALWAYS:     take = 1'b1;
         C_DISPATCH:   take = 1'b1;
         C_NO_REQ:     take = flags.no_req;
         C_INS_BAD:    take = flags.ins_bad;
         C_FULL:       take = flags.full;
         C_EMPTY:      take = flags.empty;
         C_DEL_BAD:    take = flags.del_bad;
         C_SCAN_BUSY:  take = flags.scan_busy;
         C_SHIFT_BUSY: take = flags.shift_busy;
         C_FOUND:      take = flags.found;
         C_OUT_BUSY:   take = flags.out_busy;
         default:      take = 1'b0;
      endcase
      if (cw.cond == C_DISPATCH) begin
         upc_in = dispatch(flags.op);
      end else if (take) begin
         upc_in = cw.tgt;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctl.act    = cw.act;
   assign ctl.st_set = cw.st_set;
   assign ctl.st     = cw.st;

endmodule

// File: hdl/bale_dp.sv
// Datapath: request latch, entry memory with registered read, pointers,
// scan compare and result register. Depends on bale_pkg.
module bale_dp #(
   parameter int CAPACITY = bale_pkg::CAPACITY_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bale_pkg::ctl_type          ctl,
   output bale_pkg::flags_type        flags,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_op,
   input  logic [6:0]                 req_position,
   input  logic signed [31:0]         req_key_id,
   input  logic [7:0]                 req_age,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic [5:0]                 rsp_index,
   output logic [6:0]                 rsp_count
);
   import bale_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 7) ? CW : 7;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [ENTRY_W-1:0]     mem_ff [CAPACITY];

   op_type                 op_ff;
   logic [6:0]             pos_ff;
   logic signed [ID_W-1:0] key_ff;
   logic [AGE_W-1:0]       age_ff;

   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [CW-1:0]          ptr_ff, ptr_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic                   found_ff, found_in;
   status_type             status_ff, status_in;
   logic                   rd_vld_ff;
   logic [AW-1:0]          rd_idx_ff;
   logic [ENTRY_W-1:0]     rd_data_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [5:0]             rsp_index_ff;
   logic [6:0]             rsp_count_ff;

   logic                   accept;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic                   emit;
   logic                   hit;
   logic                   more_up;
   logic                   more_dn;
   logic [XW-1:0]          pos_x;
   logic [XW-1:0]          cnt_x;
   logic [XW-1:0]          idx_x;
   logic signed [ID_W-1:0] rd_id;

   assign accept    = (ctl.act == ACT_ACCEPT) && req_valid;
   assign req_stall = (ctl.act != ACT_ACCEPT);

   assign pos_x   = XW'(pos_ff);
   assign cnt_x   = XW'(cnt_ff);
   assign idx_x   = XW'(idx_ff);
   assign rd_id   = rd_data_ff[ENTRY_W-1 -: ID_W];
   assign more_up = ptr_ff > idx_ff;
   assign more_dn = ptr_ff < cnt_ff;

   // Sorted insert stops at the first id not below the key; locate at an equal id.
   assign hit = rd_vld_ff && ((op_ff == OP_SRT) ? (rd_id >= key_ff) : (rd_id == key_ff));

   always_comb begin
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      status_in = status_ff;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = rd_idx_ff;
      wr_data   = rd_data_ff;
      emit      = 1'b0;
      unique case (ctl.act)
         ACT_INS_INIT: begin
            idx_in = pos_x[CW-1:0];
            ptr_in = cnt_ff;
         end
         ACT_SCAN_INIT: begin
            ptr_in   = '0;
            found_in = 1'b0;
         end
         ACT_SCAN: begin
            found_in = hit;
            if (hit) begin
               idx_in = CW'(rd_idx_ff);
            end else if (more_dn) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ACT_IDX_CNT: idx_in = cnt_ff;
         ACT_PTR_CNT: ptr_in = cnt_ff;
         ACT_SHIFT_UP: begin
            // read entry ptr-1 and write the beat read last cycle one slot higher
            if (more_up) begin
               rd_en   = 1'b1;
               rd_addr = AW'(ptr_ff - 1'b1);
               ptr_in  = ptr_ff - 1'b1;
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(rd_idx_ff + 1'b1);
            end
         end
         ACT_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = {key_ff, age_ff};
            cnt_in  = cnt_ff + 1'b1;
         end
         ACT_DEL_INIT: begin
            ptr_in = pos_x[CW-1:0] + 1'b1;
            idx_in = '0;
         end
         ACT_SHIFT_DN: begin
            if (more_dn) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(rd_idx_ff - 1'b1);
            end
         end
         ACT_CNT_DEC: cnt_in = cnt_ff - 1'b1;
         ACT_EMIT:    emit = 1'b1;
         default: ;
      endcase
      if (ctl.st_set) begin
         status_in = ctl.st;
         if (ctl.st != ST_OK) begin
            idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_op);
         pos_ff <= req_position;
         key_ff <= req_key_id;
         age_ff <= req_age;
      end
      ptr_ff    <= ptr_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      if (emit) begin
         rsp_status_ff <= status_ff;
         rsp_index_ff  <= idx_x[5:0];
         rsp_count_ff  <= cnt_x[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_en;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_count  = rsp_count_ff;

   assign flags.no_req     = !req_valid;
   assign flags.ins_bad    = pos_x > cnt_x;
   assign flags.full       = (cnt_ff == CAP_C);
   assign flags.empty      = (cnt_ff == '0);
   assign flags.del_bad    = pos_x >= cnt_x;
   assign flags.scan_busy  = !hit && (more_dn || rd_vld_ff);
   assign flags.shift_busy = rd_vld_ff || ((ctl.act == ACT_SHIFT_UP) ? more_up : more_dn);
   assign flags.found      = found_ff;
   assign flags.out_busy   = rsp_valid_ff && rsp_stall;
   assign flags.op         = op_ff;

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CAP_C)
      else $error("entry count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      (ctl.act == ACT_PLACE) |-> (cnt_ff < CAP_C))
      else $error("record placed into a full list");

   assert property (@(posedge clock) disable iff (reset)
      !((ctl.act == ACT_PLACE) || (ctl.act == ACT_CNT_DEC)) |=> $stable(cnt_ff))
      else $error("entry count moved outside place or delete");

   assert property (@(posedge clock) disable iff (reset)
      (ctl.act == ACT_ACCEPT) |-> !rd_vld_ff)
      else $error("memory read still in flight while taking a request");

endmodule

// File: hdl/bounded_array_list_engine_core.sv
// Bounded ordered list of (id, age) records held in one simple dual-port
// memory and run by a small microcoded sequencer. One request is handled at a
// time; a finished result sits in the output register while the next request
// is taken. A locate or the search of a sorted insert walks the list up to the
// hit or to its end, an insert moves the entry at the target and every entry
// above it up by one and a delete moves every entry above the target down by
// one; a result is held back while the one before it still waits on rsp_stall.
// The memory's one read and one write per cycle set the walk to one entry a
// cycle. Entries are never cleared; only entries below the count are read.
module bounded_array_list_engine_core #(
   parameter int CAPACITY = bale_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_key_id,
   input  logic [7:0]         req_age,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_index,
   output logic [6:0]         rsp_count
);
   import bale_pkg::*;

   ctl_type   ctl;
   flags_type flags;

   bale_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   bale_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .flags        (flags),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_position (req_position),
      .req_key_id   (req_key_id),
      .req_age      (req_age),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_index    (rsp_index),
      .rsp_count    (rsp_count)
   );

endmodule
